[hw/rtl/jtgc_pkg.sv]
package jtgc_pkg;

    // Field widths
    localparam int KIND_W   = 4;
    localparam int STRLEN_W = 25;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Register widths
    localparam int DLIM_W = 9;
    localparam int SLIM_W = 25;
    localparam int ELIM_W = 21;

    // Defaults for a zero limit
    localparam int DEF_NEST_DEPTH   = 256;
    localparam int DEF_STRING_BYTES = 16 * 1024 * 1024;
    localparam int DEF_ELEMENTS     = 1024 * 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRING_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIL_COMMA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONFINITE    = 3'd4;

    // Token kinds
    localparam logic [KIND_W-1:0] TK_NULL     = 4'd0;
    localparam logic [KIND_W-1:0] TK_TRUE     = 4'd1;
    localparam logic [KIND_W-1:0] TK_FALSE    = 4'd2;
    localparam logic [KIND_W-1:0] TK_NUMBER   = 4'd3;
    localparam logic [KIND_W-1:0] TK_STRING   = 4'd4;
    localparam logic [KIND_W-1:0] TK_LBRACKET = 4'd5;
    localparam logic [KIND_W-1:0] TK_RBRACKET = 4'd6;
    localparam logic [KIND_W-1:0] TK_LBRACE   = 4'd7;
    localparam logic [KIND_W-1:0] TK_RBRACE   = 4'd8;
    localparam logic [KIND_W-1:0] TK_COMMA    = 4'd9;
    localparam logic [KIND_W-1:0] TK_COLON    = 4'd10;
    localparam logic [KIND_W-1:0] TK_NAN      = 4'd11;
    localparam logic [KIND_W-1:0] TK_INF      = 4'd12;
    localparam logic [KIND_W-1:0] TK_NEG_INF  = 4'd13;
    localparam logic [KIND_W-1:0] TK_END      = 4'd14;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEPTH       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONFINITE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_GARBAGE     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_LEXER       = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DEPTH_W-1:0]  current_depth;
        logic                document_complete;
    } result_t;

endpackage

[hw/rtl/jtgc_if.sv]
interface jtgc_token_if;
    logic                            valid;
    logic                            ready;
    logic [jtgc_pkg::KIND_W-1:0]     token_kind;
    logic [jtgc_pkg::STRLEN_W-1:0]   string_length;
    logic                            lexer_fault;

    modport source (output valid, token_kind, string_length, lexer_fault, input ready);
    modport sink   (input valid, token_kind, string_length, lexer_fault, output ready);
endinterface

interface jtgc_result_if;
    logic                            valid;
    logic                            ready;
    logic [jtgc_pkg::STATUS_W-1:0]   status;
    logic [jtgc_pkg::DEPTH_W-1:0]    current_depth;
    logic                            document_complete;

    modport source (output valid, status, current_depth, document_complete, input ready);
    modport sink   (input valid, status, current_depth, document_complete, output ready);
endinterface

interface jtgc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [jtgc_pkg::CFG_IDX_W-1:0]  index;
    logic [jtgc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/json_token_grammar_checker.sv]
// Channel   Modport  Payload                                          Transaction
// tokens    sink     token_kind, string_length, lexer_fault           valid & ready
// results   source   status, current_depth, document_complete         valid & ready
// cfg_wr    sink     index, data                                      valid & ready (always ready)
//
// One token per cycle while the skid entry is empty; results come from registered outputs.
// The rate is set by the top-of-stack registers and the registered parent prefetch from the
// container stack memory; a push writes the old top back, a pop takes the prefetched parent.
// Reset clears control state only; the stack memory is not cleared (never read before a push).
// A two-entry output buffer keeps tokens flowing while one result waits on results; tokens
// stop only when both entries are full.
module json_token_grammar_checker #(
    parameter int MAX_NEST_DEPTH   = jtgc_pkg::DEF_NEST_DEPTH,
    parameter int MAX_ELEMENTS     = jtgc_pkg::DEF_ELEMENTS,
    parameter int MAX_STRING_BYTES = jtgc_pkg::DEF_STRING_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    jtgc_token_if.sink           tokens,
    jtgc_result_if.source        results,
    jtgc_cfg_if.sink             cfg_wr
);

    localparam int LW = $clog2(MAX_NEST_DEPTH + 1);
    localparam int AW = (MAX_NEST_DEPTH > 1) ? $clog2(MAX_NEST_DEPTH) : 1;
    localparam int DW = (LW > jtgc_pkg::DLIM_W) ? LW : jtgc_pkg::DLIM_W;
    localparam int ELIM_TOP = (1 << jtgc_pkg::ELIM_W) - 1;
    localparam int ELEM_CAP = (MAX_ELEMENTS > ELIM_TOP) ? MAX_ELEMENTS : ELIM_TOP;
    localparam int CW = $clog2(ELEM_CAP + 1);

    // Parse phases
    localparam logic [3:0] PH_ROOT      = 4'd0;
    localparam logic [3:0] PH_DONE      = 4'd1;
    localparam logic [3:0] PH_ARR_FIRST = 4'd2;
    localparam logic [3:0] PH_ARR_VALUE = 4'd3;
    localparam logic [3:0] PH_ARR_NEXT  = 4'd4;
    localparam logic [3:0] PH_OBJ_FIRST = 4'd5;
    localparam logic [3:0] PH_OBJ_KEY   = 4'd6;
    localparam logic [3:0] PH_OBJ_COLON = 4'd7;
    localparam logic [3:0] PH_OBJ_VALUE = 4'd8;
    localparam logic [3:0] PH_OBJ_NEXT  = 4'd9;

    // Configuration
    logic [jtgc_pkg::DLIM_W-1:0] depth_limit_reg;
    logic [jtgc_pkg::SLIM_W-1:0] string_limit_reg;
    logic [jtgc_pkg::ELIM_W-1:0] element_limit_reg;
    logic                        trailing_comma_ok_reg;
    logic                        nonfinite_ok_reg;

    // Parser state; top container lives in flops, the rest in the stack memory
    logic [3:0]                    phase_reg, phase_next;
    logic [LW-1:0]                 level_reg, level_next;
    logic [jtgc_pkg::STATUS_W-1:0] sticky_reg, sticky_next;
    logic                          top_kind_reg, top_kind_next;
    logic [CW-1:0]                 top_count_reg, top_count_next;

    // Stack memory: {kind, count}
    logic [CW:0]   stack_mem [MAX_NEST_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [CW:0]   rd_data_reg;
    logic          byp_reg;
    logic [CW:0]   byp_data_reg;
    logic [CW:0]   parent;

    // Output buffer
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    jtgc_pkg::result_t    out_reg;
    jtgc_pkg::result_t    skid_reg;
    jtgc_pkg::result_t    res_new;

    logic accept;
    logic drain;

    // Decoded token and grammar result
    logic [DW-1:0]                 eff_depth;
    logic [jtgc_pkg::SLIM_W-1:0]   eff_string;
    logic [CW-1:0]                 eff_elems;
    logic                          top_full;
    logic                          len_over;
    logic                          is_end;
    logic [jtgc_pkg::STATUS_W-1:0] v_st;
    logic                          v_push;
    logic                          v_done;
    logic [jtgc_pkg::STATUS_W-1:0] g_st;
    logic                          g_push;
    logic                          g_done;
    logic                          g_pop;
    logic                          g_phase_set;
    logic [3:0]                    g_phase;
    logic [jtgc_pkg::STATUS_W-1:0] st;
    logic                          act;
    logic [LW-1:0]                 level_dec;
    logic [LW-1:0]                 rd_level;

    assign cfg_wr.ready = 1'b1;
    assign tokens.ready = !skid_valid_reg;
    assign accept = tokens.valid && tokens.ready;
    assign drain  = out_valid_reg && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg       <= '0;
            string_limit_reg      <= '0;
            element_limit_reg     <= '0;
            trailing_comma_ok_reg <= 1'b0;
            nonfinite_ok_reg      <= 1'b0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                jtgc_pkg::REG_DEPTH_LIMIT:  depth_limit_reg <= cfg_wr.data[jtgc_pkg::DLIM_W-1:0];
                jtgc_pkg::REG_STRING_LIMIT: string_limit_reg <= cfg_wr.data[jtgc_pkg::SLIM_W-1:0];
                jtgc_pkg::REG_ELEM_LIMIT:   element_limit_reg <= cfg_wr.data[jtgc_pkg::ELIM_W-1:0];
                jtgc_pkg::REG_TRAIL_COMMA:  trailing_comma_ok_reg <= cfg_wr.data[0];
                jtgc_pkg::REG_NONFINITE:    nonfinite_ok_reg <= cfg_wr.data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective limits
    always_comb
    begin
        if (depth_limit_reg == '0 || DW'(depth_limit_reg) > DW'(MAX_NEST_DEPTH))
            eff_depth = DW'(MAX_NEST_DEPTH);
        else
            eff_depth = DW'(depth_limit_reg);
        eff_string = (string_limit_reg == '0) ? jtgc_pkg::SLIM_W'(MAX_STRING_BYTES)
                                              : string_limit_reg;
        eff_elems  = (element_limit_reg == '0) ? CW'(MAX_ELEMENTS) : CW'(element_limit_reg);
    end

    assign top_full = top_count_reg >= eff_elems;
    assign len_over = tokens.string_length > eff_string;
    assign is_end   = !tokens.lexer_fault && tokens.token_kind == jtgc_pkg::TK_END;

    // Token in a value position
    always_comb
    begin
        v_st   = jtgc_pkg::ST_OK;
        v_push = 1'b0;
        v_done = 1'b0;
        unique case (tokens.token_kind) inside
            jtgc_pkg::TK_NULL, jtgc_pkg::TK_TRUE, jtgc_pkg::TK_FALSE, jtgc_pkg::TK_NUMBER:
                v_done = 1'b1;
            jtgc_pkg::TK_STRING:
            begin
                if (len_over)
                    v_st = jtgc_pkg::ST_LIMIT;
                else
                    v_done = 1'b1;
            end
            jtgc_pkg::TK_LBRACKET, jtgc_pkg::TK_LBRACE:
            begin
                if (DW'(level_reg) >= eff_depth)
                    v_st = jtgc_pkg::ST_DEPTH;
                else
                    v_push = 1'b1;
            end
            jtgc_pkg::TK_NAN, jtgc_pkg::TK_INF, jtgc_pkg::TK_NEG_INF:
                v_st = nonfinite_ok_reg ? jtgc_pkg::ST_UNSUPPORTED : jtgc_pkg::ST_NONFINITE;
            default:
                v_st = jtgc_pkg::ST_BAD;
        endcase
    end

    // Grammar by phase
    always_comb
    begin
        g_st        = jtgc_pkg::ST_OK;
        g_push      = 1'b0;
        g_done      = 1'b0;
        g_pop       = 1'b0;
        g_phase_set = 1'b0;
        g_phase     = phase_reg;
        unique case (phase_reg)
            PH_ROOT, PH_OBJ_VALUE:
            begin
                g_st   = v_st;
                g_push = v_push;
                g_done = v_done;
            end
            PH_DONE:
                g_st = (tokens.token_kind == jtgc_pkg::TK_END) ? jtgc_pkg::ST_OK
                                                               : jtgc_pkg::ST_GARBAGE;
            PH_ARR_FIRST, PH_ARR_VALUE:
            begin
                if (tokens.token_kind == jtgc_pkg::TK_RBRACKET)
                begin
                    if (phase_reg == PH_ARR_VALUE && !trailing_comma_ok_reg)
                        g_st = jtgc_pkg::ST_BAD;
                    else
                        g_pop = 1'b1;
                end
                else if (top_full)
                    g_st = jtgc_pkg::ST_LIMIT;
                else
                begin
                    g_st   = v_st;
                    g_push = v_push;
                    g_done = v_done;
                end
            end
            PH_ARR_NEXT:
            begin
                if (tokens.token_kind == jtgc_pkg::TK_COMMA)
                begin
                    g_phase_set = 1'b1;
                    g_phase     = PH_ARR_VALUE;
                end
                else if (tokens.token_kind == jtgc_pkg::TK_RBRACKET)
                    g_pop = 1'b1;
                else
                    g_st = jtgc_pkg::ST_BAD;
            end
            PH_OBJ_FIRST, PH_OBJ_KEY:
            begin
                if (tokens.token_kind == jtgc_pkg::TK_RBRACE)
                begin
                    if (phase_reg == PH_OBJ_KEY && !trailing_comma_ok_reg)
                        g_st = jtgc_pkg::ST_BAD;
                    else
                        g_pop = 1'b1;
                end
                else if (tokens.token_kind == jtgc_pkg::TK_STRING)
                begin
                    if (len_over)
                        g_st = jtgc_pkg::ST_LIMIT;
                    else
                    begin
                        g_phase_set = 1'b1;
                        g_phase     = PH_OBJ_COLON;
                    end
                end
                else
                    g_st = jtgc_pkg::ST_BAD;
            end
            PH_OBJ_COLON:
            begin
                if (tokens.token_kind != jtgc_pkg::TK_COLON)
                    g_st = jtgc_pkg::ST_BAD;
                else if (top_full)
                    g_st = jtgc_pkg::ST_LIMIT;
                else
                begin
                    g_phase_set = 1'b1;
                    g_phase     = PH_OBJ_VALUE;
                end
            end
            PH_OBJ_NEXT:
            begin
                if (tokens.token_kind == jtgc_pkg::TK_COMMA)
                begin
                    g_phase_set = 1'b1;
                    g_phase     = PH_OBJ_KEY;
                end
                else if (tokens.token_kind == jtgc_pkg::TK_RBRACE)
                    g_pop = 1'b1;
                else
                    g_st = jtgc_pkg::ST_BAD;
            end
            default:
                g_st = jtgc_pkg::ST_BAD;
        endcase
    end

    // Sticky error and lexer fault take precedence; only a clean token moves the parser
    always_comb
    begin
        if (sticky_reg != jtgc_pkg::ST_OK)
            st = sticky_reg;
        else if (tokens.lexer_fault)
            st = jtgc_pkg::ST_LEXER;
        else
            st = g_st;
        act = accept && sticky_reg == jtgc_pkg::ST_OK && !tokens.lexer_fault
              && g_st == jtgc_pkg::ST_OK;
    end

    assign parent    = byp_reg ? byp_data_reg : rd_data_reg;
    assign level_dec = level_reg - LW'(1);

    // Next parser state
    always_comb
    begin
        phase_next     = phase_reg;
        level_next     = level_reg;
        top_kind_next  = top_kind_reg;
        top_count_next = top_count_reg;
        sticky_next    = sticky_reg;
        mem_we         = 1'b0;
        mem_wa         = level_dec[AW-1:0];

        if (act)
        begin
            if (g_push)
            begin
                // Old top goes back to memory; new container starts empty
                mem_we         = level_reg != '0;
                level_next     = level_reg + LW'(1);
                top_kind_next  = tokens.token_kind == jtgc_pkg::TK_LBRACE;
                top_count_next = '0;
                phase_next     = (tokens.token_kind == jtgc_pkg::TK_LBRACE) ? PH_OBJ_FIRST
                                                                             : PH_ARR_FIRST;
            end
            else if (g_done)
            begin
                if (level_reg == '0)
                    phase_next = PH_DONE;
                else
                begin
                    top_count_next = top_count_reg + CW'(1);
                    phase_next     = top_kind_reg ? PH_OBJ_NEXT : PH_ARR_NEXT;
                end
            end
            else if (g_pop)
            begin
                level_next = level_dec;
                if (level_dec == '0)
                    phase_next = PH_DONE;
                else
                begin
                    // Prefetched parent becomes the top, counting the closed container
                    top_kind_next  = parent[CW];
                    top_count_next = parent[CW-1:0] + CW'(1);
                    phase_next     = parent[CW] ? PH_OBJ_NEXT : PH_ARR_NEXT;
                end
            end
            else if (g_phase_set)
                phase_next = g_phase;
        end

        if (accept && st != jtgc_pkg::ST_OK)
            sticky_next = st;

        res_new.status            = st;
        res_new.document_complete = st == jtgc_pkg::ST_OK && phase_next == PH_DONE;

        if (accept && is_end)
        begin
            level_next  = '0;
            phase_next  = PH_ROOT;
            sticky_next = jtgc_pkg::ST_OK;
        end

        res_new.current_depth = jtgc_pkg::DEPTH_W'(level_next);
    end

    // Prefetch the parent of the next top
    assign rd_level = (level_next < LW'(2)) ? '0 : level_next - LW'(2);
    assign mem_ra   = rd_level[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_wa] <= {top_kind_reg, top_count_reg};
        rd_data_reg  <= stack_mem[mem_ra];
        byp_data_reg <= {top_kind_reg, top_count_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ROOT;
            level_reg      <= '0;
            sticky_reg     <= jtgc_pkg::ST_OK;
            top_kind_reg   <= 1'b0;
            top_count_reg  <= '0;
            byp_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            sticky_reg    <= sticky_next;
            top_kind_reg  <= top_kind_next;
            top_count_reg <= top_count_next;
            byp_reg       <= mem_we && mem_wa == mem_ra;
            if (accept)
            begin
                if (!out_valid_reg || drain)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (drain)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || drain)
                out_reg <= res_new;
            else
                skid_reg <= res_new;
        end
        else if (drain && skid_valid_reg)
            out_reg <= skid_reg;
    end

    assign results.valid             = out_valid_reg;
    assign results.status            = out_reg.status;
    assign results.current_depth     = out_reg.current_depth;
    assign results.document_complete = out_reg.document_complete;

endmodule
